// ----- hdl/tnts_pkg.sv -----
// ----------------------------------------------------------------------------
// tnts_pkg: shared types and constants for the temporal neighbor top-k selector
// Command and register codes, score constants and the search token type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tnts_pkg;

    // Defaults for the top-level parameters
    localparam int TOPK_SLOTS_DEF = 8;
    localparam int MAX_SCAN_DEF   = 128;
    localparam int MAX_FANOUT_DEF = 64;

    // At most this many entries are ever emitted per target
    localparam int RESULT_LIMIT = 8;
    localparam int SLOT_IDX_W   = 3;

    // Command codes
    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_CAND   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_KEEP_BUDGET = 2'd0;
    localparam logic [1:0] REG_VALID_SCAN  = 2'd1;
    localparam logic [1:0] REG_EVENT_TOTAL = 2'd2;
    localparam logic [1:0] REG_VERTEX_TOTAL = 2'd3;

    // Configuration reset values
    localparam logic [3:0] KEEP_BUDGET_RST = 4'd4;
    localparam logic [6:0] VALID_SCAN_RST  = 7'd16;

    // Recency score: SCORE_BASE - SCORE_STEP * min(delta, DELTA_CLAMP)
    localparam logic [11:0] SCORE_BASE  = 12'd2048;
    localparam logic [10:0] SCORE_STEP  = 11'd12;
    localparam logic [6:0]  DELTA_CLAMP = 7'd127;

    // Minimum-search token handed from cell to cell
    typedef struct packed {
        logic                  act;
        logic [11:0]           min_score;
        logic [SLOT_IDX_W-1:0] idx;
    } tnts_token_t;

endpackage

// ----- hdl/tnts_cell.sv -----
// ----------------------------------------------------------------------------
// tnts_cell: one kept-neighbor slot
// Holds one entry and updates the passing minimum-search token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnts_cell #(
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [3:0]             budget,
    input  tnts_pkg::tnts_token_t  tok_in,
    output tnts_pkg::tnts_token_t  tok_out,
    input  logic                   wr_en,
    input  logic [31:0]            wr_event,
    input  logic [31:0]            wr_peer,
    input  logic [11:0]            wr_score,
    output logic [31:0]            rd_event,
    output logic [31:0]            rd_peer,
    output logic [11:0]            rd_score
);
    import tnts_pkg::*;

    logic [31:0] event_reg;
    logic [31:0] peer_reg;
    logic [11:0] score_reg;
    tnts_token_t tok_reg;
    tnts_token_t tok_next;

    // Take over the token when this is cell 0, or when this slot lies below the budget and holds a strictly lower score
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.act && ((IDX == 0) ||
            ((4'(IDX) < budget) && (score_reg < tok_in.min_score))))
        begin
            tok_next.min_score = score_reg;
            tok_next.idx       = SLOT_IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            event_reg <= wr_event;
            peer_reg  <= wr_peer;
            score_reg <= wr_score;
        end
    end

    assign tok_out  = tok_reg;
    assign rd_event = event_reg;
    assign rd_peer  = peer_reg;
    assign rd_score = score_reg;

endmodule

// ----- hdl/temporal_neighbor_topk_select_unit.sv -----
// ----------------------------------------------------------------------------
// temporal_neighbor_topk_select_unit: recency top-k neighbor selector
// Throughput: one word at a time; in_stall holds the input while an item is at work.
// Begin, skipped candidate, unused command: idle state only. Valid candidate: offer
// state appends it, or drops it with a zero budget; on a full list the search state
// walks a token over N = min(TOPK_SLOTS, 8) cells. Finish: emit state, stalls with output.
// Reset (rst_n, async) empties the list and counters and loads config defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module temporal_neighbor_topk_select_unit #(
    parameter int TOPK_SLOTS = tnts_pkg::TOPK_SLOTS_DEF,
    parameter int MAX_SCAN   = tnts_pkg::MAX_SCAN_DEF,
    parameter int MAX_FANOUT = tnts_pkg::MAX_FANOUT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] cutoff_event,
    input  logic [31:0] anchor_time,
    input  logic [31:0] cand_event,
    input  logic [31:0] cand_peer,
    input  logic [31:0] cand_time,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        entry_valid,
    output logic [31:0] kept_event,
    output logic [31:0] kept_peer,
    output logic [11:0] kept_score,
    output logic [3:0]  kept_total,
    output logic [7:0]  scanned_steps,
    output logic        last_item
);
    import tnts_pkg::*;

    // Only the first RESULT_LIMIT slots can ever be used
    localparam int NUM_CELLS = (TOPK_SLOTS < RESULT_LIMIT) ? TOPK_SLOTS : RESULT_LIMIT;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_OFFER  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  keep_budget_reg;
    logic [6:0]  valid_scan_reg;
    logic [31:0] event_total_reg;
    logic [31:0] vertex_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_budget_reg  <= KEEP_BUDGET_RST;
            valid_scan_reg   <= VALID_SCAN_RST;
            event_total_reg  <= '0;
            vertex_total_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KEEP_BUDGET:  keep_budget_reg  <= wr_data[3:0];
                REG_VALID_SCAN:   valid_scan_reg   <= wr_data[6:0];
                REG_EVENT_TOTAL:  event_total_reg  <= wr_data;
                REG_VERTEX_TOTAL: vertex_total_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [1:0]  state_reg, state_next;
    logic [3:0]  slot_count_reg, slot_count_next;
    logic [6:0]  valid_count_reg, valid_count_next;
    logic [7:0]  scan_count_reg, scan_count_next;
    logic [31:0] saved_cutoff_reg, saved_cutoff_next;
    logic [31:0] saved_time_reg, saved_time_next;
    logic [3:0]  emit_idx_reg, emit_idx_next;
    logic        out_valid_reg, out_valid_next;

    // Candidate held between acceptance and its offer to the list
    logic [31:0] cand_event_reg, cand_peer_reg;
    logic [6:0]  bucket_reg;
    logic        cand_load;

    // Output word register
    logic        entry_valid_reg;
    logic [31:0] kept_event_reg, kept_peer_reg;
    logic [11:0] kept_score_reg;
    logic [3:0]  kept_total_reg;
    logic [7:0]  scanned_reg;
    logic        last_item_reg;
    logic        out_load;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    tnts_token_t tok_chain [NUM_CELLS+1];
    logic [31:0] cell_event [NUM_CELLS];
    logic [31:0] cell_peer  [NUM_CELLS];
    logic [11:0] cell_score [NUM_CELLS];
    logic        cell_wr    [NUM_CELLS];

    logic              tok_launch;
    logic              slot_wr;
    logic [CELL_W-1:0] slot_wr_idx;
    logic [3:0]        eff_keep;
    logic [11:0]       cand_score;
    logic [10:0]       score_drop;
    tnts_token_t       tok_last;

    // Launch token enters the first cell; cell 0 always seeds the minimum
    always_comb
    begin
        tok_chain[0]           = '0;
        tok_chain[0].act       = tok_launch;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            assign cell_wr[gi] = slot_wr && (slot_wr_idx == CELL_W'(gi));

            tnts_cell #(
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .budget   (eff_keep),
                .tok_in   (tok_chain[gi]),
                .tok_out  (tok_chain[gi+1]),
                .wr_en    (cell_wr[gi]),
                .wr_event (cand_event_reg),
                .wr_peer  (cand_peer_reg),
                .wr_score (cand_score),
                .rd_event (cell_event[gi]),
                .rd_peer  (cell_peer[gi]),
                .rd_score (cell_score[gi])
            );
        end
    endgenerate

    assign tok_last = tok_chain[NUM_CELLS];

    // Effective keep budget: saturate to the number of cells
    assign eff_keep = (keep_budget_reg > 4'(NUM_CELLS)) ? 4'(NUM_CELLS) : keep_budget_reg;

    // Recency score of the held candidate
    assign score_drop = 11'(bucket_reg) * SCORE_STEP;
    assign cand_score = SCORE_BASE - 12'(score_drop);

    // ------------------------------------------------------------------
    // Candidate qualification (combinational on the input word)
    // ------------------------------------------------------------------
    logic [6:0]  scan_vbudget;
    logic        scan_stop;
    logic        cand_ok;
    logic [31:0] delta;
    logic [6:0]  bucket_in;

    assign scan_vbudget = (valid_scan_reg < 7'(MAX_FANOUT)) ? valid_scan_reg : 7'(MAX_FANOUT);
    assign scan_stop    = (valid_count_reg >= scan_vbudget) || (scan_count_reg >= 8'(MAX_SCAN));
    assign cand_ok      = (cand_event < saved_cutoff_reg) && (cand_event < event_total_reg) &&
                          (cand_peer < vertex_total_reg);
    assign delta        = saved_time_reg - cand_time;
    assign bucket_in    = (delta < 32'(DELTA_CLAMP) + 32'd1) ? delta[6:0] : DELTA_CLAMP;

    // Hold the input side for the whole time one item is at work
    assign in_stall = (state_reg != ST_IDLE);

    // Load a new output word when the register is empty or being drained
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        slot_count_next   = slot_count_reg;
        valid_count_next  = valid_count_reg;
        scan_count_next   = scan_count_reg;
        saved_cutoff_next = saved_cutoff_reg;
        saved_time_next   = saved_time_reg;
        emit_idx_next     = emit_idx_reg;
        cand_load         = 1'b0;
        tok_launch        = 1'b0;
        slot_wr           = 1'b0;
        slot_wr_idx       = slot_count_reg[CELL_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_BEGIN:
                        begin
                            saved_cutoff_next = cutoff_event;
                            saved_time_next   = anchor_time;
                            slot_count_next   = '0;
                            valid_count_next  = '0;
                            scan_count_next   = '0;
                        end
                        CMD_CAND:
                        begin
                            // Once the scan budget is spent, drop without counting
                            if (!scan_stop)
                            begin
                                if (scan_count_reg != 8'hFF)
                                begin
                                    scan_count_next = scan_count_reg + 8'd1;
                                end
                                if (cand_ok)
                                begin
                                    valid_count_next = valid_count_reg + 7'd1;
                                    cand_load        = 1'b1;
                                    state_next       = ST_OFFER;
                                end
                            end
                        end
                        CMD_FINISH:
                        begin
                            emit_idx_next = '0;
                            state_next    = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end

            ST_OFFER:
            begin
                if (eff_keep == 4'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_count_reg < eff_keep)
                begin
                    // Append into the next free slot
                    slot_wr         = 1'b1;
                    slot_count_next = slot_count_reg + 4'd1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    // List full: walk the token to find the first lowest score
                    tok_launch = 1'b1;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (tok_last.act)
                begin
                    slot_wr_idx = tok_last.idx[CELL_W-1:0];
                    slot_wr     = (cand_score > tok_last.min_score);
                    state_next  = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (out_load)
                begin
                    emit_idx_next = emit_idx_reg + 4'd1;
                    if ((slot_count_reg == 4'd0) || (emit_idx_reg + 4'd1 == slot_count_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_count_reg   <= '0;
            valid_count_reg  <= '0;
            scan_count_reg   <= '0;
            saved_cutoff_reg <= '0;
            saved_time_reg   <= '0;
            emit_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_count_reg   <= slot_count_next;
            valid_count_reg  <= valid_count_next;
            scan_count_reg   <= scan_count_next;
            saved_cutoff_reg <= saved_cutoff_next;
            saved_time_reg   <= saved_time_next;
            emit_idx_reg     <= emit_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Candidate holding register
    always_ff @(posedge clk)
    begin
        if (cand_load)
        begin
            cand_event_reg <= cand_event;
            cand_peer_reg  <= cand_peer;
            bucket_reg     <= bucket_in;
        end
    end

    // Output word: an empty list gives one marker word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            scanned_reg <= scan_count_reg;
            if (slot_count_reg == 4'd0)
            begin
                entry_valid_reg <= 1'b0;
                kept_event_reg  <= '0;
                kept_peer_reg   <= '0;
                kept_score_reg  <= '0;
                kept_total_reg  <= '0;
                last_item_reg   <= 1'b1;
            end
            else
            begin
                entry_valid_reg <= 1'b1;
                kept_event_reg  <= cell_event[emit_idx_reg[CELL_W-1:0]];
                kept_peer_reg   <= cell_peer[emit_idx_reg[CELL_W-1:0]];
                kept_score_reg  <= cell_score[emit_idx_reg[CELL_W-1:0]];
                kept_total_reg  <= slot_count_reg;
                last_item_reg   <= (emit_idx_reg + 4'd1 == slot_count_reg);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_valid   = entry_valid_reg;
    assign kept_event    = kept_event_reg;
    assign kept_peer     = kept_peer_reg;
    assign kept_score    = kept_score_reg;
    assign kept_total    = kept_total_reg;
    assign scanned_steps = scanned_reg;
    assign last_item     = last_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_token_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.act |-> (state_reg == ST_SEARCH))
        else $error("search token left the chain outside a search");

    a_slot_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_count_reg <= 4'(NUM_CELLS))
        else $error("slot count exceeds the number of cells");

    a_list_stable_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |=> (slot_count_reg == $past(slot_count_reg)))
        else $error("slot count changed during a minimum search");

    a_valid_below_scanned: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, valid_count_reg} <= scan_count_reg)
        else $error("valid count exceeds scanned count");

    a_emit_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> in_stall)
        else $error("output word loaded while input side is open");

endmodule

// ----- bench/tb_temporal_neighbor_topk_select_unit.sv -----
// ----------------------------------------------------------------------------
// tb_temporal_neighbor_topk_select_unit: self-checking bench for the selector
// Drives begin, candidate and finish words with random idling on both sides,
// keeps its own model of the kept list and compares every emitted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_temporal_neighbor_topk_select_unit;
    import tnts_pkg::*;

    // Command code that the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int SLOTS        = TOPK_SLOTS_DEF;
    localparam int SCAN_CEILING = MAX_SCAN_DEF;
    localparam int FANOUT_CAP   = MAX_FANOUT_DEF;

    // Recency score: top score minus a fixed drop per time unit of age
    localparam int SCORE_TOP  = 2048;
    localparam int SCORE_DROP = 12;
    localparam int AGE_CLAMP  = 127;

    // Longest busy stretch without a word out is a full-list replace
    localparam int SETTLE_CYCLES = 16;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // One emitted word, laid out in port order
    typedef struct packed {
        logic        hit;
        logic [31:0] ev;
        logic [31:0] peer;
        logic [11:0] score;
        logic [3:0]  total;
        logic [7:0]  scanned;
        logic        last;
    } neighbor_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = 2'd0;
    logic [31:0] wr_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_BEGIN;
    logic [31:0] cutoff_event = 32'd0;
    logic [31:0] anchor_time = 32'd0;
    logic [31:0] cand_event = 32'd0;
    logic [31:0] cand_peer = 32'd0;
    logic [31:0] cand_time = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        entry_valid;
    logic [31:0] kept_event;
    logic [31:0] kept_peer;
    logic [11:0] kept_score;
    logic [3:0]  kept_total;
    logic [7:0]  scanned_steps;
    logic        last_item;

    // Idle rates in percent for the sender and the receiver
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;

    // Our copy of the configuration registers (reset values)
    logic [3:0]  keep_reg = 4'd4;
    logic [6:0]  scan_budget_reg = 7'd16;
    logic [31:0] event_limit_reg = 32'd0;
    logic [31:0] vertex_limit_reg = 32'd0;

    // Our copy of the per-target state
    logic [31:0] kept_ev_q [SLOTS];
    logic [31:0] kept_peer_q [SLOTS];
    logic [11:0] kept_score_q [SLOTS];
    int          kept_n = 0;
    int          valid_seen = 0;
    int          scan_seen = 0;
    logic [31:0] tgt_cutoff = 32'd0;
    logic [31:0] tgt_time = 32'd0;

    // Words still owed by the block, oldest first
    neighbor_word_t pending_neighbors [$];
    neighbor_word_t got_word;
    neighbor_word_t want_word;

    temporal_neighbor_topk_select_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .cutoff_event  (cutoff_event),
        .anchor_time   (anchor_time),
        .cand_event    (cand_event),
        .cand_peer     (cand_peer),
        .cand_time     (cand_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .entry_valid   (entry_valid),
        .kept_event    (kept_event),
        .kept_peer     (kept_peer),
        .kept_score    (kept_score),
        .kept_total    (kept_total),
        .scanned_steps (scanned_steps),
        .last_item     (last_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("[temporal_neighbor_topk_select_unit] ERROR");
        $finish;
    end

    // Receiver: stall at random, one decision per cycle
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Update the selection model with one accepted word and queue what it emits.
    task automatic predict_selection(input logic [1:0] cmd, input logic [31:0] cut,
                                     input logic [31:0] tt, input logic [31:0] ev,
                                     input logic [31:0] peer, input logic [31:0] ct);
        int             keep_eff;
        int             scan_cap;
        int             lo;
        int             n;
        int             bucket;
        logic [31:0]    age;
        logic [11:0]    score;
        logic [7:0]     scanned;
        neighbor_word_t w;
        scanned = (scan_seen > 255) ? 8'd255 : 8'(scan_seen);
        case (cmd)
            CMD_BEGIN:
            begin
                tgt_cutoff = cut;
                tgt_time = tt;
                kept_n = 0;
                valid_seen = 0;
                scan_seen = 0;
            end
            CMD_CAND:
            begin
                scan_cap = (int'(scan_budget_reg) < FANOUT_CAP) ? int'(scan_budget_reg)
                                                                : FANOUT_CAP;
                // Drop everything once either scan budget is spent
                if (valid_seen < scan_cap && scan_seen < SCAN_CEILING)
                begin
                    if (scan_seen < 255)
                        scan_seen++;
                    if (ev < tgt_cutoff && ev < event_limit_reg && peer < vertex_limit_reg)
                    begin
                        valid_seen++;
                        age = tgt_time - ct;
                        bucket = (age < 32'd128) ? int'(age) : AGE_CLAMP;
                        score = 12'(SCORE_TOP - SCORE_DROP * bucket);
                        keep_eff = int'(keep_reg);
                        if (keep_eff > SLOTS)
                            keep_eff = SLOTS;
                        if (keep_eff > RESULT_LIMIT)
                            keep_eff = RESULT_LIMIT;
                        if (keep_eff != 0)
                        begin
                            if (kept_n < keep_eff)
                            begin
                                kept_ev_q[kept_n] = ev;
                                kept_peer_q[kept_n] = peer;
                                kept_score_q[kept_n] = score;
                                kept_n++;
                            end
                            else
                            begin
                                // Replace the first lowest entry below the budget,
                                // only on a strictly better score
                                lo = 0;
                                for (int i = 1; i < keep_eff; i++)
                                    if (kept_score_q[i] < kept_score_q[lo])
                                        lo = i;
                                if (score > kept_score_q[lo])
                                begin
                                    kept_ev_q[lo] = ev;
                                    kept_peer_q[lo] = peer;
                                    kept_score_q[lo] = score;
                                end
                            end
                        end
                    end
                end
            end
            CMD_FINISH:
            begin
                n = kept_n;
                if (n > SLOTS)
                    n = SLOTS;
                if (n > RESULT_LIMIT)
                    n = RESULT_LIMIT;
                if (n == 0)
                begin
                    w = '0;
                    w.scanned = scanned;
                    w.last = 1'b1;
                    pending_neighbors.push_back(w);
                end
                for (int k = 0; k < n; k++)
                begin
                    w.hit = 1'b1;
                    w.ev = kept_ev_q[k];
                    w.peer = kept_peer_q[k];
                    w.score = kept_score_q[k];
                    w.total = 4'(n);
                    w.scanned = scanned;
                    w.last = (k + 1 == n);
                    pending_neighbors.push_back(w);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Present one word, idling first at random; return once it is accepted.
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] cut,
                             input logic [31:0] tt, input logic [31:0] ev,
                             input logic [31:0] peer, input logic [31:0] ct);
        int gap;
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            // Drop valid and scramble the payload while idle
            in_valid <= 1'b0;
            command <= 2'($urandom);
            cutoff_event <= $urandom;
            anchor_time <= $urandom;
            cand_event <= $urandom;
            cand_peer <= $urandom;
            cand_time <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        cutoff_event <= cut;
        anchor_time <= tt;
        cand_event <= ev;
        cand_peer <= peer;
        cand_time <= ct;
        // Hold the word until the block takes it
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_selection(cmd, cut, tt, ev, peer, ct);
    endtask

    // Write one register and mirror it into the model.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        wr_index <= 2'($urandom);
        wr_data <= $urandom;
        case (idx)
            REG_KEEP_BUDGET:  keep_reg = data[3:0];
            REG_VALID_SCAN:   scan_budget_reg = data[6:0];
            REG_EVENT_TOTAL:  event_limit_reg = data;
            REG_VERTEX_TOTAL: vertex_limit_reg = data;
            default:          ;
        endcase
    endtask

    // Wait until every owed word is out and the block has had time to go idle.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Candidate before any begin uses the zero cut-off and is skipped but
    // counted; the unused command is ignored; finish gives the empty marker.
    task automatic test_before_begin();
        send_word(CMD_CAND, $urandom, $urandom, 32'd0, 32'd0, 32'd0);
        send_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_word(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Ranking, skip rules, time wrap, ties and a repeated finish.
    task automatic test_ranking();
        settle();
        write_register(REG_KEEP_BUDGET, 32'd3);
        write_register(REG_VALID_SCAN, 32'd16);
        write_register(REG_EVENT_TOTAL, 32'd1000);
        write_register(REG_VERTEX_TOTAL, 32'd100);
        send_word(CMD_BEGIN, 32'd500, 32'd1000, $urandom, $urandom, $urandom);
        send_word(CMD_CAND, $urandom, $urandom, 32'd10, 32'd1, 32'd1000);
        // event beyond the cut-off, then peer at the vertex count: both skipped
        send_word(CMD_CAND, $urandom, $urandom, 32'd700, 32'd2, 32'd1000);
        send_word(CMD_CAND, $urandom, $urandom, 32'd20, 32'd100, 32'd1000);
        // timestamp after the target wraps to a huge age: lowest score
        send_word(CMD_CAND, $urandom, $urandom, 32'd30, 32'd3, 32'd2000);
        send_word(CMD_CAND, $urandom, $urandom, 32'd40, 32'd4, 32'd995);
        // tie with the minimum must not replace it; a better one must
        send_word(CMD_CAND, $urandom, $urandom, 32'd50, 32'd5, 32'd873);
        send_word(CMD_CAND, $urandom, $urandom, 32'd60, 32'd99, 32'd999);
        send_word(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_word(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
        // Widest cut-off, target time zero, candidate time all ones
        send_word(CMD_BEGIN, ALL_ONES, 32'd0, $urandom, $urandom, $urandom);
        send_word(CMD_CAND, $urandom, $urandom, 32'd1500, 32'd7, 32'd0);
        send_word(CMD_CAND, $urandom, $urandom, 32'd999, 32'd99, ALL_ONES);
        send_word(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Shrink the budget on a full list, then grow it, inside one target.
    task automatic test_budget_change();
        settle();
        send_word(CMD_BEGIN, 32'd1000, 32'd5000, $urandom, $urandom, $urandom);
        send_word(CMD_CAND, $urandom, $urandom, 32'd1, 32'd1, 32'd4900);
        send_word(CMD_CAND, $urandom, $urandom, 32'd2, 32'd2, 32'd4990);
        send_word(CMD_CAND, $urandom, $urandom, 32'd3, 32'd3, 32'd4950);
        settle();
        write_register(REG_KEEP_BUDGET, 32'd2);
        send_word(CMD_CAND, $urandom, $urandom, 32'd4, 32'd4, 32'd5000);
        settle();
        write_register(REG_KEEP_BUDGET, 32'd5);
        send_word(CMD_CAND, $urandom, $urandom, 32'd5, 32'd5, 32'd4000);
        send_word(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Zero keep budget keeps nothing; the valid-scan budget stops counting.
    task automatic test_scan_budget_stop();
        settle();
        write_register(REG_KEEP_BUDGET, 32'd0);
        write_register(REG_VALID_SCAN, 32'd2);
        send_word(CMD_BEGIN, 32'd1000, 32'd0, $urandom, $urandom, $urandom);
        for (int i = 1; i <= 3; i++)
            send_word(CMD_CAND, $urandom, $urandom, i, i, 32'd0);
        send_word(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Mostly well-formed targets with random content, plus unused commands,
    // stray candidates and abandoned targets; registers change between targets.
    task automatic run_random_targets(input int send_pct, input int stall_pct,
                                      input int quota);
        int          sent;
        int          pick;
        int          n_cand;
        logic [31:0] cut;
        logic [31:0] tt;
        logic [31:0] ev;
        logic [31:0] peer;
        logic [31:0] ct;
        logic [31:0] ev_lim;
        logic [31:0] data;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        tt = $urandom;
        while (sent < quota)
        begin
            if (sent == 0 || $urandom_range(0, 3) == 0)
            begin
                settle();
                // Keep budget: mostly 1..8, sometimes zero or past the slot count
                data = $urandom;
                data[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(1, 8));
                write_register(REG_KEEP_BUDGET, data);
                data = $urandom;
                data[6:0] = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(1, 20));
                write_register(REG_VALID_SCAN, data);
                for (int r = 0; r < 2; r++)
                begin
                    case ($urandom_range(0, 7))
                        0, 1:    data = ALL_ONES;
                        2:       data = $urandom;
                        3:       data = 32'd0;
                        default: data = $urandom_range(1, 3000);
                    endcase
                    write_register((r == 0) ? REG_EVENT_TOTAL : REG_VERTEX_TOTAL, data);
                end
            end
            pick = $urandom_range(0, 99);
            n_cand = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 12);
            if (pick >= 78 && pick < 86)
            begin
                send_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
                sent++;
            end
            else
            begin
                // Open a target unless this is a run of stray candidates
                if (pick < 78 || pick >= 94)
                begin
                    case ($urandom_range(0, 9))
                        0, 1:    cut = ALL_ONES;
                        2, 3:    cut = $urandom_range(0, 3000);
                        4:       cut = 32'd0;
                        default: cut = $urandom;
                    endcase
                    case ($urandom_range(0, 7))
                        0:       tt = 32'd0;
                        1:       tt = ALL_ONES;
                        2:       tt = $urandom_range(0, 100);
                        default: tt = $urandom;
                    endcase
                    send_word(CMD_BEGIN, cut, tt, $urandom, $urandom, $urandom);
                    sent++;
                end
                if (pick >= 78)
                    n_cand = $urandom_range(1, 6);
                ev_lim = (tgt_cutoff < event_limit_reg) ? tgt_cutoff : event_limit_reg;
                for (int i = 0; i < n_cand; i++)
                begin
                    ev = (ev_lim != 0 && $urandom_range(0, 99) < 75)
                         ? $urandom_range(ev_lim - 1, 0) : $urandom;
                    peer = (vertex_limit_reg != 0 && $urandom_range(0, 99) < 80)
                           ? $urandom_range(vertex_limit_reg - 1, 0) : $urandom;
                    case ($urandom_range(0, 5))
                        0, 1, 2: ct = tgt_time - $urandom_range(0, 140);
                        3:       ct = tgt_time - $urandom_range(0, 20);
                        4:       ct = tgt_time + $urandom_range(1, 60);
                        default: ct = $urandom;
                    endcase
                    send_word(CMD_CAND, $urandom, $urandom, ev, peer, ct);
                    sent++;
                end
                // Abandoned targets end without a finish
                if (pick < 94)
                begin
                    send_word(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
                    sent++;
                end
            end
        end
    endtask

    // Compare every word taken from the block against the oldest owed word.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_word = {entry_valid, kept_event, kept_peer, kept_score, kept_total,
                        scanned_steps, last_item};
            if (pending_neighbors.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word hit=%0d ev=%0h peer=%0h score=%0d total=%0d",
                         $time, got_word.hit, got_word.ev, got_word.peer, got_word.score,
                         got_word.total, " scanned=%0d last=%0d",
                         got_word.scanned, got_word.last);
            end
            else
            begin
                want_word = pending_neighbors.pop_front();
                if (got_word !== want_word)
                begin
                    mismatches++;
                    $display("%0t: word mismatch expected hit=%0d ev=%0h peer=%0h",
                             $time, want_word.hit, want_word.ev, want_word.peer,
                             " score=%0d total=%0d scanned=%0d last=%0d",
                             want_word.score, want_word.total, want_word.scanned,
                             want_word.last,
                             " actual hit=%0d ev=%0h peer=%0h score=%0d total=%0d",
                             got_word.hit, got_word.ev, got_word.peer, got_word.score,
                             got_word.total, " scanned=%0d last=%0d",
                             got_word.scanned, got_word.last);
                end
            end
        end
    end

    // Test sequence: directed cases first, then three random rounds that move
    // the idling from the receiver to the sender and finally switch it off.
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_stall_pct = 64;
        test_before_begin();
        test_ranking();
        test_budget_change();
        test_scan_budget_stop();
        run_random_targets(13, 64, 25);
        run_random_targets(64, 13, 25);
        run_random_targets(0, 0, 25);
        settle();
        if (mismatches == 0)
            $display("[temporal_neighbor_topk_select_unit] OK");
        else
            $display("[temporal_neighbor_topk_select_unit] ERROR");
        $finish;
    end

endmodule

// ----- temporal_neighbor_topk_select_unit.f -----
hdl/tnts_pkg.sv
hdl/tnts_cell.sv
hdl/temporal_neighbor_topk_select_unit.sv
bench/tb_temporal_neighbor_topk_select_unit.sv
